// ===== rtl/core/bounded_doubly_linked_list_assert.svh =====
// assertion macros for the linked list block
`ifndef BOUNDED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BDLL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define BDLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/bdll_pkg.sv =====
// package with shared types and constants for the linked list block
`timescale 1ns / 1ps
package bdll_pkg;
	localparam int unsigned DefCapacity   = 16;
	localparam int unsigned DefValueWidth = 32;

	localparam logic [2:0] OP_INS_HEAD = 3'd0;
	localparam logic [2:0] OP_INS_TAIL = 3'd1;
	localparam logic [2:0] OP_INS_AT   = 3'd2;
	localparam logic [2:0] OP_DEL_HEAD = 3'd3;
	localparam logic [2:0] OP_DEL_TAIL = 3'd4;
	localparam logic [2:0] OP_DEL_AT   = 3'd5;
	localparam logic [2:0] OP_SHOW_FWD = 3'd6;
	localparam logic [2:0] OP_SHOW_BWD = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_LINK,
		S_SHOW,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, reset walk
		logic walk_step; // advance walk pointer along next
		logic link;      // perform insert/delete update
		logic show_emit; // load output with current node, step
		logic resp_emit; // load single status output
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       walk_done;
		logic       is_show;
		logic       is_mod;
		logic       err;
		logic       show_last;
		logic       out_busy;
	} stat_t;
endpackage

// ===== rtl/core/bdll_ctrl.sv =====
// controller state machine for the linked list block
`timescale 1ns / 1ps
`include "bounded_doubly_linked_list_assert.svh"
module bdll_ctrl import bdll_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_WALK;
			S_WALK: begin
				if (stat.walk_done) begin
					if (stat.err) state_d = S_RESP;
					else if (stat.is_show) state_d = S_SHOW;
					else state_d = S_LINK;
				end
			end
			S_LINK: state_d = S_RESP;
			S_SHOW: if (!stat.out_busy && stat.show_last) state_d = S_IDLE;
			S_RESP: if (!stat.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_WALK: cmd.walk_step = !stat.walk_done;
			S_LINK: cmd.link = 1'b1;
			S_SHOW: cmd.show_emit = !stat.out_busy;
			S_RESP: cmd.resp_emit = !stat.out_busy;
			default: ;
		endcase
	end

	`BDLL_ASSERT_IMP(a_ready_idle, in_ready, state_q == S_IDLE)
	`BDLL_ASSERT_NEXT(a_link_resp, state_q == S_LINK, state_q == S_RESP)
	`BDLL_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd))
endmodule

// ===== rtl/core/bdll_dp.sv =====
// datapath with node store, free stack, walk pointer and output register
`timescale 1ns / 1ps
`include "bounded_doubly_linked_list_assert.svh"
module bdll_dp import bdll_pkg::*; #(
	parameter int unsigned CAPACITY    = DefCapacity,
	parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  op,
	input  logic [31:0] value,
	input  logic [7:0]  position,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] item_value,
	output logic        last,
	output logic [4:0]  length
);
	localparam int unsigned SW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);
	localparam logic [SW-1:0] NIL = SW'(CAPACITY);

	logic [VALUE_WIDTH-1:0] vals_q [CAPACITY];
	logic [SW-1:0] nxt_q [CAPACITY];
	logic [SW-1:0] prv_q [CAPACITY];
	logic [IW-1:0] free_q [CAPACITY];
	logic [SW-1:0] free_top_q, head_q, tail_q, cnt_q;

	logic [2:0]  op_q;
	logic [31:0] val_q;
	logic [SW-1:0] k_q;    // walk target: links to advance for delete, one more than for insert
	logic [SW-1:0] steps_q;
	logic [SW-1:0] cur_q;  // walk/show slot
	logic [SW-1:0] shown_q;
	logic [1:0]  err_q;
	logic        err_v_q;

	logic out_busy;
	assign out_busy = out_valid && !out_ready;

	// request decode at load time
	logic [8:0] pos9, cnt9;
	logic       is_ins, is_del, is_show;
	logic [1:0] err_d;
	logic       err_v_d;
	logic [SW-1:0] k_d;
	assign pos9 = {1'b0, position};
	assign cnt9 = 9'(cnt_q);
	assign is_ins  = op == OP_INS_HEAD || op == OP_INS_TAIL || op == OP_INS_AT;
	assign is_del  = op == OP_DEL_HEAD || op == OP_DEL_TAIL || op == OP_DEL_AT;
	assign is_show = op == OP_SHOW_FWD || op == OP_SHOW_BWD;

	always_comb begin
		err_v_d = 1'b0;
		err_d = ST_OK;
		k_d = '0;
		if (is_ins) begin
			if (op == OP_INS_AT && (pos9 == 9'd0 || pos9 > cnt9 + 9'd1)) begin
				err_v_d = 1'b1; err_d = ST_BADPOS;
			end else if (cnt9 >= 9'(CAPACITY)) begin
				err_v_d = 1'b1; err_d = ST_FULL;
			end
			// walk to predecessor: k-1 links from head; k=0 means none
			if (op == OP_INS_AT) k_d = SW'(pos9 - 9'd1);
			else if (op == OP_INS_TAIL) k_d = cnt_q;
		end else if (is_del) begin
			if (cnt_q == '0) begin
				err_v_d = 1'b1; err_d = ST_EMPTY;
			end else if (op == OP_DEL_AT && (pos9 == 9'd0 || pos9 > cnt9)) begin
				err_v_d = 1'b1; err_d = ST_BADPOS;
			end
			if (op == OP_DEL_AT) k_d = SW'(pos9 - 9'd1);
			else if (op == OP_DEL_TAIL) k_d = cnt_q - SW'(1);
		end else begin
			if (cnt_q == '0 || (op == OP_SHOW_FWD ? head_q : tail_q) >= NIL) begin
				err_v_d = 1'b1; err_d = ST_EMPTY;
			end
		end
		if (err_v_d) k_d = '0;
	end

	// walk: insert needs slot of entry k-1 (k links minus one), delete slot of entry k
	logic q_ins, q_del, q_show;
	logic [SW-1:0] need;
	assign q_ins  = op_q == OP_INS_HEAD || op_q == OP_INS_TAIL || op_q == OP_INS_AT;
	assign q_del  = op_q == OP_DEL_HEAD || op_q == OP_DEL_TAIL || op_q == OP_DEL_AT;
	assign q_show = op_q == OP_SHOW_FWD || op_q == OP_SHOW_BWD;
	assign need = (q_ins && k_q != '0) ? k_q - SW'(1) : k_q;

	logic walk_done;
	assign walk_done = q_show || err_v_q || steps_q == need;

	assign stat.walk_done = walk_done;
	assign stat.is_show = q_show;
	assign stat.is_mod = q_ins || q_del;
	assign stat.err = err_v_q;
	assign stat.out_busy = out_busy;

	// show step
	logic [SW-1:0] show_nxt;
	logic show_fin;
	assign show_nxt = (cur_q < NIL)
		? (op_q == OP_SHOW_FWD ? nxt_q[cur_q[IW-1:0]] : prv_q[cur_q[IW-1:0]]) : NIL;
	assign show_fin = show_nxt >= NIL || (shown_q + SW'(1)) >= NIL;
	assign stat.show_last = show_fin;

	// link update values
	logic [IW-1:0] new_s;
	logic [SW-1:0] pred, after, d_before, d_after;
	assign new_s = free_q[IW'(free_top_q - SW'(1))];
	assign pred = (k_q == '0) ? NIL : cur_q;
	assign after = (pred == NIL) ? head_q : nxt_q[pred[IW-1:0]];
	assign d_before = prv_q[cur_q[IW-1:0]];
	assign d_after = nxt_q[cur_q[IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			tail_q <= NIL;
			cnt_q <= '0;
			free_top_q <= NIL;
			for (int i = 0; i < CAPACITY; i++) free_q[i] <= IW'(i);
			out_valid <= 1'b0;
		end else begin
			if (cmd.link && q_ins) begin
				free_top_q <= free_top_q - SW'(1);
				if (pred == NIL) head_q <= SW'(new_s);
				if (after >= NIL) tail_q <= SW'(new_s);
				cnt_q <= cnt_q + SW'(1);
			end
			if (cmd.link && q_del) begin
				if (d_before >= NIL) head_q <= (d_after < NIL) ? d_after : NIL;
				if (d_after >= NIL) tail_q <= (d_before < NIL) ? d_before : NIL;
				free_q[IW'(free_top_q)] <= cur_q[IW-1:0];
				free_top_q <= free_top_q + SW'(1);
				cnt_q <= cnt_q - SW'(1);
			end
			if (cmd.show_emit || cmd.resp_emit) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			val_q <= value;
			k_q <= k_d;
			err_q <= err_d;
			err_v_q <= err_v_d;
			steps_q <= '0;
			shown_q <= '0;
			cur_q <= (op == OP_SHOW_BWD) ? tail_q : head_q;
		end
		if (cmd.walk_step) begin
			steps_q <= steps_q + SW'(1);
			cur_q <= nxt_q[cur_q[IW-1:0]];
		end
		if (cmd.link && q_ins) begin
			vals_q[new_s] <= VALUE_WIDTH'({{32{val_q[31]}}, val_q});
			prv_q[new_s] <= pred;
			nxt_q[new_s] <= after;
			if (pred != NIL) nxt_q[pred[IW-1:0]] <= SW'(new_s);
			if (after < NIL) prv_q[after[IW-1:0]] <= SW'(new_s);
		end
		if (cmd.link && q_del) begin
			if (d_before < NIL) nxt_q[d_before[IW-1:0]] <= d_after;
			if (d_after < NIL) prv_q[d_after[IW-1:0]] <= d_before;
		end
		if (cmd.show_emit) begin
			status <= ST_OK;
			item_value <= 32'({{32{1'b0}}, vals_q[cur_q[IW-1:0]]});
			last <= show_fin;
			length <= 5'(cnt_q);
			cur_q <= show_nxt;
			shown_q <= shown_q + SW'(1);
		end
		if (cmd.resp_emit) begin
			status <= err_v_q ? err_q : ST_OK;
			item_value <= '0;
			last <= 1'b1;
			length <= 5'(cnt_q);
		end
	end

	`BDLL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= NIL)
	`BDLL_ASSERT_IMP(a_free_sum, 1'b1, 9'(cnt_q) + 9'(free_top_q) == 9'(CAPACITY))
	`BDLL_ASSERT_IMP(a_empty_head, cnt_q == '0, head_q == NIL && tail_q == NIL)
endmodule

// ===== rtl/core/bounded_doubly_linked_list.sv =====
// Bounded doubly linked list, top level.
// Input channel s_axis carries one request: op, value, position.
// Output channel m_axis carries results: status, item_value, length, with last.
// Insert and delete return one result; show returns one result per entry,
// last marking the final one, or one status result if the list is empty.
// A request is taken only when the block is idle; one request at a time.
// An accepted insert or delete walks forward links to the position (up to
// CAPACITY - 1 links), then updates links and loads its result; a rejected
// request loads only its status; show emits one entry per cycle unless stalled.
// The next request is taken the cycle after the final result is loaded.
// The walk along forward links, one slot per cycle, sets the rate.
// Reset empties the list and refills the free-slot stack at once;
// store contents are undefined until written.
// A stalled receiver holds the output register and further results wait;
// no result is lost or repeated.
`timescale 1ns / 1ps
module bounded_doubly_linked_list import bdll_pkg::*; #(
	parameter int unsigned CAPACITY    = DefCapacity,
	parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // op[2:0], value[34:3], position[42:35]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // status[1:0], item_value[33:2], length[38:34]
	output logic        m_axis_tlast
);
	cmd_t  cmd;
	stat_t stat;
	logic [1:0]  status;
	logic [31:0] item_value;
	logic [4:0]  length;

	bdll_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	bdll_dp #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.op(s_axis_tdata[2:0]), .value(s_axis_tdata[34:3]),
		.position(s_axis_tdata[42:35]),
		.cmd(cmd), .stat(stat),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(status), .item_value(item_value), .last(m_axis_tlast),
		.length(length)
	);

	assign m_axis_tdata = {1'b0, length, item_value, status};
endmodule
